@@ rtl/core/sesd_pkg.sv @@
// Shared types, codes and constants for the serial escape sequence detector.
package sesd_pkg;

    localparam int TIMER_BITS = 21;
    localparam int CMP_W      = (TIMER_BITS > 20) ? TIMER_BITS : 20;
    localparam int HOLD_DEPTH = 5;
    localparam int HOLD_W     = $clog2(HOLD_DEPTH + 1);
    localparam int ESC_COUNT  = 3;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] MASK_7BIT = 8'h7F;

    localparam logic [19:0] BLANK_RESET   = 20'd16384;
    localparam logic [19:0] TIMEOUT_RESET = 20'd65536;
    localparam logic [7:0]  ESCAPE_RESET  = 8'h24;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_LEAVE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_FORWARD = 2'd0,
        KIND_COMMAND = 2'd1,
        KIND_ENTER   = 2'd2,
        KIND_LEAVE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_BLANK   = 2'd0,
        REG_TIMEOUT = 2'd1,
        REG_ESCAPE  = 2'd2,
        REG_SEVEN   = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        MODE_INACTIVE = 4'b0001,
        MODE_CHECK    = 4'b0010,
        MODE_POST     = 4'b0100,
        MODE_ACTIVE   = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [19:0] blank_ticks;
        logic [19:0] timeout_ticks;
        logic [7:0]  escape_char;
        logic        seven_bit_mode;
    } cfg_t;

    typedef struct packed {
        logic [HOLD_DEPTH-1:0][7:0] held;
        logic [HOLD_W-1:0]          n_held;
        logic                       has_tail;
        kind_t                      tail_kind;
        logic [7:0]                 tail_byte;
    } job_t;

endpackage

@@ rtl/core/sesd_front.sv @@
// Front end: accepts items, tracks mode, idle time and held bytes, issues jobs.
module sesd_front
    import sesd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  accept,
    input  logic [1:0]            op,
    input  logic [7:0]            rx_byte,
    output logic                  push,
    output job_t                  job
);

    localparam logic [TIMER_BITS-1:0] IDLE_MAX = '1;

    mode_t                 mode_reg, mode_next;
    logic [TIMER_BITS-1:0] idle_reg, idle_next, idle_inc;
    logic [HOLD_W-1:0]     cnt_reg, cnt_next;
    logic [7:0]            held_reg [HOLD_DEPTH];
    logic                  wr_en;
    logic [7:0]            b;
    logic                  timed_out, blank_passed, blank_met, byte_ok;

    assign b        = cfg.seven_bit_mode ? (rx_byte & MASK_7BIT) : rx_byte;
    assign idle_inc = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 1'b1;

    assign timed_out    = CMP_W'(idle_inc) > CMP_W'(cfg.timeout_ticks);
    assign blank_passed = CMP_W'(idle_inc) > CMP_W'(cfg.blank_ticks);
    assign blank_met    = CMP_W'(idle_reg) >= CMP_W'(cfg.blank_ticks);

    always_comb
    begin
        if (cnt_reg < HOLD_W'(ESC_COUNT))
            byte_ok = (b == cfg.escape_char);
        else if (cnt_reg < HOLD_W'(HOLD_DEPTH))
            byte_ok = (b == CH_CR) || (b == CH_LF);
        else
            byte_ok = 1'b0;
    end

    always_comb
    begin
        mode_next     = mode_reg;
        idle_next     = idle_reg;
        cnt_next      = cnt_reg;
        wr_en         = 1'b0;
        push          = 1'b0;
        job.n_held    = '0;
        job.has_tail  = 1'b0;
        job.tail_kind = KIND_FORWARD;
        job.tail_byte = '0;
        for (int i = 0; i < HOLD_DEPTH; i++)
            job.held[i] = held_reg[i];
        if (accept)
        begin
            case (op)
                OP_TICK:
                begin
                    idle_next = idle_inc;
                    if ((mode_reg == MODE_CHECK || mode_reg == MODE_POST) && timed_out)
                    begin
                        push       = 1'b1;
                        job.n_held = cnt_reg;
                        mode_next  = MODE_INACTIVE;
                        idle_next  = '0;
                        cnt_next   = '0;
                    end
                    else if (mode_reg == MODE_POST && blank_passed)
                    begin
                        push          = 1'b1;
                        job.has_tail  = 1'b1;
                        job.tail_kind = KIND_ENTER;
                        mode_next     = MODE_ACTIVE;
                        cnt_next      = '0;
                    end
                end
                OP_LEAVE:
                begin
                    if (mode_reg == MODE_ACTIVE)
                    begin
                        push          = 1'b1;
                        job.has_tail  = 1'b1;
                        job.tail_kind = KIND_LEAVE;
                        mode_next     = MODE_INACTIVE;
                        idle_next     = '0;
                    end
                end
                OP_BYTE:
                begin
                    case (mode_reg)
                        MODE_INACTIVE:
                        begin
                            idle_next = '0;
                            if (b == cfg.escape_char && blank_met)
                            begin
                                mode_next = MODE_CHECK;
                                wr_en     = 1'b1;
                                cnt_next  = HOLD_W'(1);
                            end
                            else
                            begin
                                push          = 1'b1;
                                job.has_tail  = 1'b1;
                                job.tail_byte = b;
                            end
                        end
                        MODE_ACTIVE:
                        begin
                            push          = 1'b1;
                            job.has_tail  = 1'b1;
                            job.tail_kind = KIND_COMMAND;
                            job.tail_byte = b;
                        end
                        default:
                        begin
                            if (byte_ok)
                            begin
                                wr_en    = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                                if (cnt_reg == HOLD_W'(ESC_COUNT - 1) && mode_reg == MODE_CHECK)
                                begin
                                    mode_next = MODE_POST;
                                    idle_next = '0;
                                end
                            end
                            else
                            begin
                                push          = 1'b1;
                                job.n_held    = cnt_reg;
                                job.has_tail  = 1'b1;
                                job.tail_byte = b;
                                mode_next     = MODE_INACTIVE;
                                idle_next     = '0;
                                cnt_next      = '0;
                            end
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_INACTIVE;
            idle_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            idle_reg <= idle_next;
            cnt_reg  <= cnt_next;
        end
    end

    // hold the byte at the next free place; a byte in idle mode always lands first
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            if (mode_reg == MODE_INACTIVE)
                held_reg[0] <= b;
            else
                held_reg[cnt_reg] <= b;
        end
    end

endmodule

@@ rtl/core/sesd_queue.sv @@
// Short job queue between the front end and the result sequencer.
module sesd_queue
    import sesd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic empty,
    output logic full
);

    job_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

@@ rtl/core/sesd_back.sv @@
// Back end: expands queued jobs into result beats through an output register.
module sesd_back
    import sesd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  job_t       head,
    input  logic       empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] out_byte,
    output logic       last
);

    logic [HOLD_W-1:0] idx_reg;
    logic              valid_reg;
    logic [1:0]        kind_reg;
    logic [7:0]        byte_reg;
    logic              last_reg;
    logic              load, in_held, final_beat;
    logic [1:0]        beat_kind;
    logic [7:0]        beat_byte;

    assign load    = !empty && (!valid_reg || out_ready);
    assign in_held = idx_reg < head.n_held;

    always_comb
    begin
        if (in_held)
        begin
            beat_kind  = KIND_FORWARD;
            beat_byte  = head.held[idx_reg];
            final_beat = (idx_reg + 1'b1 == head.n_held) && !head.has_tail;
        end
        else
        begin
            beat_kind  = head.tail_kind;
            beat_byte  = head.tail_byte;
            final_beat = 1'b1;
        end
    end

    assign pop = load && final_beat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= final_beat ? '0 : idx_reg + 1'b1;
        end
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= beat_kind;
            byte_reg <= beat_byte;
            last_reg <= final_beat;
        end
    end

    assign out_valid = valid_reg;
    assign kind      = kind_reg;
    assign out_byte  = byte_reg;
    assign last      = last_reg;

endmodule

@@ rtl/core/serial_escape_sequence_detector.sv @@
// Top level of the serial escape sequence detector with its register port.
// Watches a received byte stream for a guarded escape sequence (silence,
// three escape characters, up to two CR/LF, silence) and switches to command
// mode. One item is taken each cycle while the four-entry job queue has room;
// the result sequencer gives one beat a cycle while a job is queued and
// out_ready is high, and a release burst holds up to six beats. The queue
// depth sets how many such bursts the input may run ahead. Registers:
// blank_ticks at 0x0, timeout_ticks at 0x4, escape_char at 0x8,
// seven_bit_mode at 0xC.
module serial_escape_sequence_detector
    import sesd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  out_byte,
    output logic        last
);

    cfg_t     cfg_reg;
    reg_idx_t sel;
    logic     cfg_wr;
    logic     in_accept;
    logic     q_push, q_pop, q_empty, q_full;
    job_t     front_job, q_head;

    assign pready = 1'b1;
    assign sel    = reg_idx_t'(paddr[3:2]);
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.blank_ticks    <= BLANK_RESET;
            cfg_reg.timeout_ticks  <= TIMEOUT_RESET;
            cfg_reg.escape_char    <= ESCAPE_RESET;
            cfg_reg.seven_bit_mode <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (sel)
                REG_BLANK:   cfg_reg.blank_ticks    <= pwdata[19:0];
                REG_TIMEOUT: cfg_reg.timeout_ticks  <= pwdata[19:0];
                REG_ESCAPE:  cfg_reg.escape_char    <= pwdata[7:0];
                REG_SEVEN:   cfg_reg.seven_bit_mode <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_BLANK:   prdata = {12'd0, cfg_reg.blank_ticks};
            REG_TIMEOUT: prdata = {12'd0, cfg_reg.timeout_ticks};
            REG_ESCAPE:  prdata = {24'd0, cfg_reg.escape_char};
            REG_SEVEN:   prdata = {31'd0, cfg_reg.seven_bit_mode};
            default:     prdata = '0;
        endcase
    end

    assign in_ready  = !q_full;
    assign in_accept = in_valid && in_ready;

    sesd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .accept  (in_accept),
        .op      (op),
        .rx_byte (rx_byte),
        .push    (q_push),
        .job     (front_job)
    );

    sesd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (front_job),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    sesd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .out_byte  (out_byte),
        .last      (last)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("job pushed into a full queue");

    a_mode_beat_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == KIND_ENTER || kind == KIND_LEAVE)) |-> (last && out_byte == 8'd0))
        else $error("mode change beat not final or carries a byte");

    a_pop_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> out_valid && last)
        else $error("job retired without a final beat");

endmodule
